// File: hdl/fqvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqvd_pkg
// Types and codes shared by the queue with delete-by-value.
// ----------------------------------------------------------------------------
package fqvd_pkg;

  typedef logic signed [31:0] data_t;
  typedef logic [1:0]         opcode_t;
  typedef logic [1:0]         status_t;
  typedef logic [4:0]         count_t;

  localparam opcode_t OP_PUSH   = 2'd0;
  localparam opcode_t OP_POP    = 2'd1;
  localparam opcode_t OP_DELETE = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// File: hdl/fqvd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqvd_in_if
// Request channel: opcode and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqvd_in_if;
  logic               valid;
  logic               ready;
  fqvd_pkg::opcode_t  opcode;
  fqvd_pkg::data_t    value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: hdl/fqvd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqvd_out_if
// Response channel: popped value, status and entry count.
// ----------------------------------------------------------------------------
interface fqvd_out_if;
  logic               valid;
  logic               ready;
  fqvd_pkg::data_t    popped_value;
  fqvd_pkg::status_t  status;
  fqvd_pkg::count_t   entry_count;

  modport source (output valid, output popped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, output ready);
endinterface

// File: hdl/fqvd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqvd_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fqvd_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  fqvd_pkg::data_t  wdata,
  input  logic [AW-1:0]    raddr,
  output fqvd_pkg::data_t  rdata
);
  import fqvd_pkg::*;

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fifo_queue_with_value_delete_unit.sv
`timescale 1ns / 1ps
// Push, pop on empty and no-op go from the idle state through the done state
// into the response register. Pop and delete scan the store one slot a cycle
// through the single read port, then move the later entries up one slot a cycle.
// One item at a time; the next request beat is taken once the result is registered.
// Reset (rst, synchronous) empties the queue, returns to idle so the request
// channel is ready, and clears the response valid; the entry store is not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_value_delete_unit
// Ordered queue with push, pop and delete of the first matching value.
// ----------------------------------------------------------------------------
module fifo_queue_with_value_delete_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  fqvd_in_if.sink     req,
  fqvd_out_if.source  rsp
);
  import fqvd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state, state_next;
  logic [CW-1:0]   occ, occ_next;
  logic [CW-1:0]   idx, idx_next;
  logic [AW-1:0]   pidx, pidx_next;
  logic [AW-1:0]   wptr, wptr_next;
  logic            pv, pv_next;
  logic            is_pop, is_pop_next;
  data_t           val, val_next;
  data_t           popped, popped_next;
  status_t         st, st_next;

  logic            out_valid, out_valid_next;
  data_t           out_pop, out_pop_next;
  status_t         out_st, out_st_next;
  count_t          out_cnt, out_cnt_next;

  logic            we;
  logic [AW-1:0]   waddr;
  data_t           wdata;
  logic [AW-1:0]   raddr;
  data_t           rdata;
  logic            match;
  logic [CW+4:0]   cnt_ext;

  fqvd_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.popped_value = out_pop;
  assign rsp.status       = out_st;
  assign rsp.entry_count  = out_cnt;

  assign match   = pv && (is_pop || (rdata == val));
  assign cnt_ext = {5'b0, occ};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      pv        <= pv_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pidx    <= pidx_next;
    wptr    <= wptr_next;
    is_pop  <= is_pop_next;
    val     <= val_next;
    popped  <= popped_next;
    st      <= st_next;
    out_pop <= out_pop_next;
    out_st  <= out_st_next;
    out_cnt <= out_cnt_next;
  end

  always_comb begin
    state_next     = state;
    occ_next       = occ;
    idx_next       = idx;
    pidx_next      = pidx;
    wptr_next      = wptr;
    pv_next        = pv;
    is_pop_next    = is_pop;
    val_next       = val;
    popped_next    = popped;
    st_next        = st;
    out_valid_next = out_valid && !rsp.ready;
    out_pop_next   = out_pop;
    out_st_next    = out_st;
    out_cnt_next   = out_cnt;
    we             = 1'b0;
    waddr          = wptr;
    wdata          = rdata;
    raddr          = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          val_next    = req.value;
          popped_next = '0;
          st_next     = ST_OK;
          pv_next     = 1'b0;
          idx_next    = '0;
          is_pop_next = (req.opcode == OP_POP);
          if (req.opcode == OP_PUSH) begin
            if (occ >= CW'(DEPTH)) begin
              st_next = ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = occ[AW-1:0];
              wdata    = req.value;
              occ_next = occ + CW'(1);
            end
            state_next = S_DONE;
          end else if (req.opcode == OP_POP) begin
            if (occ == '0) begin
              st_next    = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end else if (req.opcode == OP_DELETE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          if (is_pop) begin
            popped_next = rdata;
          end
          wptr_next  = pidx;
          idx_next   = CW'(pidx) + CW'(1);
          pv_next    = 1'b0;
          state_next = S_SHIFT;
        end else if (idx < occ) begin
          pv_next   = 1'b1;
          pidx_next = idx[AW-1:0];
          idx_next  = idx + CW'(1);
        end else begin
          st_next    = ST_NOT_FOUND;
          pv_next    = 1'b0;
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (pv) begin
          we        = 1'b1;
          wptr_next = wptr + AW'(1);
        end
        if (idx < occ) begin
          pv_next  = 1'b1;
          idx_next = idx + CW'(1);
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            occ_next   = occ - CW'(1);
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_pop_next   = popped;
          out_st_next    = st;
          out_cnt_next   = cnt_ext[4:0];
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while an item is in progress");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == OP_PUSH && occ < CW'(DEPTH))
    |=> (occ == $past(occ) + CW'(1)))
    else $error("push did not add an entry");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (occ != '0))
    else $error("compaction with an empty queue");
`endif

endmodule

// File: dv/fifo_queue_with_value_delete_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_value_delete_unit_tb
// Self-checking bench for the queue with delete-by-value. A shadow queue in the
// bench predicts popped value, status and entry count for every request beat.
// Directed corners run first, then a backpressure fill and random traffic
// under several idle mixes. Each response is compared in order.
// ----------------------------------------------------------------------------
module fifo_queue_with_value_delete_unit_tb;
  import fqvd_pkg::*;

  localparam int      DEPTH        = 16;
  localparam int      HOLD_LEN     = 200;
  localparam int      DRAIN_CYCLES = 60;
  localparam int      CYCLE_LIMIT  = 600000;
  localparam opcode_t OP_NOP       = 2'd3;

  typedef struct {
    data_t   popped_value;
    status_t status;
    count_t  entry_count;
  } queue_result_t;

  logic clk;
  logic rst;
  logic hold_req;
  int   hold_left     = 0;
  int   cycle_count   = 0;
  int   error_count   = 0;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;

  data_t         queue_image[$];
  queue_result_t expected_results[$];

  fqvd_in_if  req_if ();
  fqvd_out_if rsp_if ();

  fifo_queue_with_value_delete_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // response ready: long hold on request, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_LEN;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    queue_result_t exp_r;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, expected none, actual popped %0d status %0d count %0d",
                 $time, rsp_if.popped_value, rsp_if.status, rsp_if.entry_count);
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_if.popped_value !== exp_r.popped_value) begin
          error_count++;
          $display("%0t: popped_value expected %0d actual %0d",
                   $time, exp_r.popped_value, rsp_if.popped_value);
        end
        if (rsp_if.status !== exp_r.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_r.status, rsp_if.status);
        end
        if (rsp_if.entry_count !== exp_r.entry_count) begin
          error_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, exp_r.entry_count, rsp_if.entry_count);
        end
      end
    end
  end

  function automatic queue_result_t predict_queue_op(input opcode_t op, input data_t val);
    queue_result_t r;
    int            hit;
    r.popped_value = '0;
    r.status       = ST_OK;
    hit            = -1;
    case (op)
      OP_PUSH: begin
        if (queue_image.size() >= DEPTH) r.status = ST_FULL;
        else queue_image.push_back(val);
      end
      OP_POP: begin
        if (queue_image.size() == 0) r.status = ST_EMPTY;
        else r.popped_value = queue_image.pop_front();
      end
      OP_DELETE: begin
        foreach (queue_image[i]) begin
          if (hit < 0 && queue_image[i] == val) hit = i;
        end
        if (hit < 0) r.status = ST_NOT_FOUND;
        else queue_image.delete(hit);
      end
      default: ;
    endcase
    r.entry_count = count_t'(queue_image.size());
    return r;
  endfunction

  // mostly a small pool so duplicates and delete hits are common
  function automatic data_t pick_value(input bit prefer_present);
    int    r;
    data_t corner[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
    r = $urandom_range(9);
    if (prefer_present && queue_image.size() != 0 && r < 6)
      return queue_image[$urandom_range(queue_image.size() - 1)];
    if (r < 4) return data_t'($urandom_range(7)) - 4;
    if (r < 6) return corner[$urandom_range(3)];
    return data_t'($urandom);
  endfunction

  task automatic send_op(input opcode_t op, input data_t val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.value  <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    expected_results.push_back(predict_queue_op(op, val));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_cases();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_op(OP_POP, 32'sd9);
    send_op(OP_DELETE, 32'sd0);
    send_op(OP_NOP, -32'sd1);
    wait_results_drained();
  endtask

  task automatic test_fill_and_delete();
    data_t fill_vals[16] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1,
                             32'sd5, 32'sd5, 32'sd17, -32'sd17,
                             32'sd1, 32'sd2, 32'sd3, 32'sd4,
                             32'sd5, 32'sd6, 32'sd7, 32'sd100};
    foreach (fill_vals[i]) send_op(OP_PUSH, fill_vals[i]);
    send_op(OP_PUSH, 32'sd42);
    send_op(OP_DELETE, 32'sd5);
    send_op(OP_DELETE, 32'sd100);
    send_op(OP_DELETE, 32'sh8000_0000);
    send_op(OP_DELETE, 32'sd999);
    send_op(OP_POP, 32'sd0);
    send_op(OP_NOP, 32'sd0);
    wait_results_drained();
  endtask

  task automatic test_backpressure_fill();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 30; k++) begin
      if (k < 20) send_op(OP_PUSH, pick_value(1'b0));
      else if (k % 2 == 0) send_op(OP_DELETE, pick_value(1'b1));
      else send_op(OP_POP, pick_value(1'b0));
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
    int      push_pct;
    int      r;
    opcode_t op;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    push_pct      = 50;
    for (int k = 0; k < n_items; k++) begin
      // bias shifts so the queue swings between empty and full
      if (k % 40 == 0) push_pct = 25 + 25 * $urandom_range(2);
      r = $urandom_range(99);
      if (r < 3) op = OP_NOP;
      else if (r < push_pct) op = OP_PUSH;
      else if ($urandom_range(1)) op = OP_POP;
      else op = OP_DELETE;
      send_op(op, pick_value(op == OP_DELETE));
    end
    wait_results_drained();
  endtask

  initial begin
    rst           <= 1'b1;
    hold_req      <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_PUSH;
    req_if.value  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_cases();
    test_fill_and_delete();
    test_backpressure_fill();
    test_random_traffic(380, 31, 49);
    test_random_traffic(380, 49, 31);
    test_random_traffic(380, 0, 0);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fqvd_pkg.sv
hdl/fqvd_in_if.sv
hdl/fqvd_out_if.sv
hdl/fqvd_ram.sv
hdl/fifo_queue_with_value_delete_unit.sv
dv/fifo_queue_with_value_delete_unit_tb.sv
